>>> hdl/sfcs_pkg.sv
`default_nettype none

package sfcs_pkg;

    localparam int ADDR_FIELD_W = 24;
    localparam int LEN_W        = 25;
    localparam int BYTE_W       = 8;

    localparam int PAGE_BYTES_DEF = 256;
    localparam int ADDR_BITS_DEF  = 24;

    localparam logic [LEN_W-1:0] DEVICE_SIZE_RESET = 25'h100_0000;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    // flash opcodes
    localparam logic [BYTE_W-1:0] OP_WREN   = 8'h06;
    localparam logic [BYTE_W-1:0] OP_WRDI   = 8'h04;
    localparam logic [BYTE_W-1:0] OP_RDSR   = 8'h05;
    localparam logic [BYTE_W-1:0] OP_WRSR   = 8'h01;
    localparam logic [BYTE_W-1:0] OP_READ   = 8'h03;
    localparam logic [BYTE_W-1:0] OP_PROG   = 8'hAD;
    localparam logic [BYTE_W-1:0] OP_BULK   = 8'hC7;
    localparam logic [BYTE_W-1:0] OP_RDID   = 8'h9F;
    localparam logic [BYTE_W-1:0] PAUSE_BYTE = 8'hFF;

    // status register bits
    localparam logic [BYTE_W-1:0] SR_BUSY = 8'h01;
    localparam logic [BYTE_W-1:0] SR_WEL  = 8'h02;
    localparam logic [BYTE_W-1:0] SR_BP   = 8'h3C;

    typedef enum logic [2:0] {
        MODE_READ    = 3'd0,
        MODE_WRITE   = 3'd1,
        MODE_ERASE   = 3'd2,
        MODE_ID      = 3'd3,
        MODE_REPLY   = 3'd4,
        MODE_PAYLOAD = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        OPER_READ  = 2'd0,
        OPER_WRITE = 2'd1,
        OPER_ERASE = 2'd2,
        OPER_ID    = 2'd3
    } oper_t;

    typedef enum logic [2:0] {
        KIND_XFER = 3'd0,
        KIND_DATA = 3'd1,
        KIND_WANT = 3'd2,
        KIND_DONE = 3'd3,
        KIND_ERR  = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_POLL_CMD, ST_POLL_READ, ST_POLL_PAUSE, ST_WREN_CMD,
        ST_WREN_PAUSE, ST_WRSR_CMD, ST_WRSR_VAL, ST_WRSR_PAUSE, ST_OPCODE,
        ST_ADDR, ST_RD_DATA, ST_PAY_WAIT, ST_PAY_SENT, ST_PG_PAUSE,
        ST_WRDI_CMD, ST_WRDI_PAUSE, ST_ID_DATA, ST_END_PAUSE
    } step_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] spi_byte;
        logic              select_active;
        logic [BYTE_W-1:0] host_byte;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } res_pair_t;

    function automatic res_t mk_xfer(logic [BYTE_W-1:0] b, logic sel);
        res_t r;
        r.kind          = KIND_XFER;
        r.spi_byte      = b;
        r.select_active = sel;
        r.host_byte     = '0;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic res_t mk_kind(kind_t k);
        res_t r;
        r.kind          = k;
        r.spi_byte      = '0;
        r.select_active = 1'b0;
        r.host_byte     = '0;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic res_t mk_data(logic [BYTE_W-1:0] h);
        res_t r;
        r.kind          = KIND_DATA;
        r.spi_byte      = '0;
        r.select_active = 1'b0;
        r.host_byte     = h;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sfcs_core.sv
`default_nettype none

module sfcs_core
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    fire,
    input  wire logic [2:0]              mode,
    input  wire logic [ADDR_FIELD_W-1:0] address,
    input  wire logic [LEN_W-1:0]        length,
    input  wire logic [BYTE_W-1:0]       data_byte,
    input  wire logic [LEN_W-1:0]        device_size,
    output res_pair_t                    res
);

    // page size is a power of two
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
    localparam int PG_W       = PAGE_BITS + 1;
    localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;
    localparam logic [1:0] ADDR_ID_INIT = 2'(ADDR_BYTES - 1);
    localparam logic [1:0] ID_INIT      = 2'd3;
    localparam logic [LEN_W-1:0] ADDR_SPAN = LEN_W'(1) << ADDR_BITS;

    step_t                 step_reg, step_next;
    oper_t                 op_reg, op_next;
    logic [ADDR_BITS-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]      rem_reg, rem_next;
    logic [PG_W-1:0]       pg_reg, pg_next;
    logic [BYTE_W-1:0]     stat_reg, stat_next;
    logic [1:0]            id_reg, id_next;

    mode_t                 mode_c;
    logic                  is_rw;
    logic                  range_bad;
    logic [LEN_W-1:0]      limit;
    logic [LEN_W:0]        req_end;
    logic [ADDR_BITS-1:0]  addr_m;
    logic [ADDR_BITS-1:0]  cur_inc;
    logic [LEN_W-1:0]      rem_dec;
    logic [PG_W-1:0]       pg_dec;
    logic [1:0]            id_dec;
    logic [PG_W-1:0]       pg_req;
    logic [PG_W-1:0]       pg_cur;
    logic                  prot;
    step_t                 wren_after_step;
    step_t                 poll_after_step;
    logic [BYTE_W-1:0]     wren_after_byte;
    logic [BYTE_W-1:0]     poll_after_byte;
    logic [ADDR_FIELD_W-1:0] cur_ext;
    logic [BYTE_W-1:0]     addr_first;
    logic [BYTE_W-1:0]     addr_more;

    function automatic logic [PG_W-1:0] page_room(logic [ADDR_BITS-1:0] a,
                                                  logic [LEN_W-1:0] n);
        logic [PG_W-1:0] room;
        room = PG_W'(PAGE_BYTES) - PG_W'(a[PAGE_BITS-1:0]);
        return (LEN_W'(room) < n) ? room : PG_W'(n);
    endfunction

    function automatic logic [BYTE_W-1:0] addr_sel(logic [ADDR_FIELD_W-1:0] a,
                                                   logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            2'd0:    b = a[7:0];
            2'd1:    b = a[15:8];
            2'd2:    b = a[23:16];
            default: b = '0;
        endcase
        return b;
    endfunction

    assign mode_c    = mode_t'(mode);
    assign is_rw     = (mode_c == MODE_READ) || (mode_c == MODE_WRITE);
    assign limit     = (device_size < ADDR_SPAN) ? device_size : ADDR_SPAN;
    assign req_end   = (LEN_W+1)'(address) + (LEN_W+1)'(length);
    assign range_bad = req_end > (LEN_W+1)'(limit);
    assign addr_m    = address[ADDR_BITS-1:0];
    assign cur_inc   = cur_reg + ADDR_BITS'(1);
    assign rem_dec   = (rem_reg != '0) ? rem_reg - LEN_W'(1) : '0;
    assign pg_dec    = (pg_reg != '0) ? pg_reg - PG_W'(1) : '0;
    assign id_dec    = (id_reg != '0) ? id_reg - 2'd1 : '0;
    assign pg_req    = page_room(addr_m, length);
    assign pg_cur    = page_room(cur_reg, rem_reg);
    assign prot      = (stat_reg & SR_BP) != '0;
    assign cur_ext   = ADDR_FIELD_W'(cur_reg);
    assign addr_first = addr_sel(cur_ext, ADDR_ID_INIT);
    assign addr_more  = addr_sel(cur_ext, id_dec);

    // write enable is followed by erase opcode, protect clear, or program opcode
    always_comb begin
        if (op_reg != OPER_ERASE && prot) begin
            wren_after_step = ST_WRSR_CMD;
        end else begin
            wren_after_step = ST_OPCODE;
        end
        if (op_reg == OPER_ERASE) begin
            wren_after_byte = OP_BULK;
        end else if (prot) begin
            wren_after_byte = OP_WRSR;
        end else begin
            wren_after_byte = OP_PROG;
        end
    end

    always_comb begin
        if (op_reg == OPER_READ || op_reg == OPER_ID) begin
            poll_after_step = ST_OPCODE;
        end else if ((stat_reg & SR_WEL) == '0) begin
            poll_after_step = ST_WREN_CMD;
        end else begin
            poll_after_step = wren_after_step;
        end
        if (op_reg == OPER_READ) begin
            poll_after_byte = OP_READ;
        end else if (op_reg == OPER_ID) begin
            poll_after_byte = OP_RDID;
        end else if ((stat_reg & SR_WEL) == '0) begin
            poll_after_byte = OP_WREN;
        end else begin
            poll_after_byte = wren_after_byte;
        end
    end

    // next state
    always_comb begin
        step_next = step_reg;
        op_next   = op_reg;
        cur_next  = cur_reg;
        rem_next  = rem_reg;
        pg_next   = pg_reg;
        stat_next = stat_reg;
        id_next   = id_reg;
        if (fire) begin
            case (mode_c)
                MODE_READ, MODE_WRITE, MODE_ERASE, MODE_ID: begin
                    if (step_reg == ST_IDLE && !(is_rw && range_bad)) begin
                        if (is_rw) begin
                            cur_next = addr_m;
                            rem_next = length;
                        end
                        if (!(mode_c == MODE_WRITE && length == '0)) begin
                            if (mode_c == MODE_WRITE) begin
                                pg_next = pg_req;
                            end
                            op_next   = oper_t'(mode[1:0]);
                            step_next = ST_POLL_CMD;
                        end
                    end
                end
                MODE_REPLY: begin
                    unique case (step_reg)
                        ST_POLL_CMD:   step_next = ST_POLL_READ;
                        ST_POLL_READ: begin
                            stat_next = data_byte;
                            step_next = ST_POLL_PAUSE;
                        end
                        ST_POLL_PAUSE: begin
                            step_next = ((stat_reg & SR_BUSY) != '0) ? ST_POLL_CMD
                                                                     : poll_after_step;
                        end
                        ST_WREN_CMD:   step_next = ST_WREN_PAUSE;
                        ST_WREN_PAUSE: step_next = wren_after_step;
                        ST_WRSR_CMD:   step_next = ST_WRSR_VAL;
                        ST_WRSR_VAL:   step_next = ST_WRSR_PAUSE;
                        ST_WRSR_PAUSE: step_next = ST_OPCODE;
                        ST_OPCODE: begin
                            if (op_reg == OPER_ERASE) begin
                                step_next = ST_END_PAUSE;
                            end else if (op_reg == OPER_ID) begin
                                id_next   = ID_INIT;
                                step_next = ST_ID_DATA;
                            end else begin
                                id_next   = ADDR_ID_INIT;
                                step_next = ST_ADDR;
                            end
                        end
                        ST_ADDR: begin
                            if (id_reg != '0) begin
                                id_next = id_dec;
                            end else if (op_reg == OPER_READ) begin
                                step_next = (rem_reg != '0) ? ST_RD_DATA : ST_END_PAUSE;
                            end else begin
                                step_next = ST_PAY_WAIT;
                            end
                        end
                        ST_RD_DATA: begin
                            rem_next  = rem_dec;
                            cur_next  = cur_inc;
                            step_next = (rem_dec != '0) ? ST_RD_DATA : ST_END_PAUSE;
                        end
                        ST_ID_DATA: begin
                            id_next   = id_dec;
                            step_next = (id_dec != '0) ? ST_ID_DATA : ST_END_PAUSE;
                        end
                        ST_PAY_SENT: begin
                            pg_next   = pg_dec;
                            rem_next  = rem_dec;
                            cur_next  = cur_inc;
                            step_next = (pg_dec != '0) ? ST_PAY_WAIT : ST_PG_PAUSE;
                        end
                        ST_PG_PAUSE:   step_next = ST_WRDI_CMD;
                        ST_WRDI_CMD:   step_next = ST_WRDI_PAUSE;
                        ST_WRDI_PAUSE: begin
                            if (rem_reg != '0) begin
                                pg_next   = pg_cur;
                                step_next = ST_POLL_CMD;
                            end else begin
                                step_next = ST_IDLE;
                            end
                        end
                        ST_END_PAUSE:  step_next = ST_IDLE;
                        default: ;
                    endcase
                end
                MODE_PAYLOAD: begin
                    if (step_reg == ST_PAY_WAIT) begin
                        step_next = ST_PAY_SENT;
                    end
                end
                default: ;
            endcase
        end
    end

    // results
    always_comb begin
        res.count = 2'd0;
        res.r0    = mk_kind(KIND_DONE);
        res.r1    = mk_kind(KIND_DONE);
        if (fire) begin
            case (mode_c)
                MODE_READ, MODE_WRITE, MODE_ERASE, MODE_ID: begin
                    if (step_reg == ST_IDLE) begin
                        res.count = 2'd1;
                        if (is_rw && range_bad) begin
                            res.r0 = mk_kind(KIND_ERR);
                        end else if (mode_c == MODE_WRITE && length == '0) begin
                            res.r0 = mk_kind(KIND_DONE);
                        end else begin
                            res.r0 = mk_xfer(OP_RDSR, 1'b1);
                        end
                    end
                end
                MODE_REPLY: begin
                    res.count = 2'd1;
                    unique case (step_reg)
                        ST_POLL_CMD:   res.r0 = mk_xfer(PAUSE_BYTE, 1'b1);
                        ST_POLL_READ:  res.r0 = mk_xfer(PAUSE_BYTE, 1'b0);
                        ST_POLL_PAUSE: begin
                            res.r0 = ((stat_reg & SR_BUSY) != '0)
                                     ? mk_xfer(OP_RDSR, 1'b1) : mk_xfer(poll_after_byte, 1'b1);
                        end
                        ST_WREN_CMD:   res.r0 = mk_xfer(PAUSE_BYTE, 1'b0);
                        ST_WREN_PAUSE: res.r0 = mk_xfer(wren_after_byte, 1'b1);
                        ST_WRSR_CMD:   res.r0 = mk_xfer(stat_reg & ~SR_BP, 1'b1);
                        ST_WRSR_VAL:   res.r0 = mk_xfer(PAUSE_BYTE, 1'b0);
                        ST_WRSR_PAUSE: res.r0 = mk_xfer(OP_PROG, 1'b1);
                        ST_OPCODE: begin
                            if (op_reg == OPER_ERASE) begin
                                res.r0 = mk_xfer(PAUSE_BYTE, 1'b0);
                            end else if (op_reg == OPER_ID) begin
                                res.r0 = mk_xfer(PAUSE_BYTE, 1'b1);
                            end else begin
                                res.r0 = mk_xfer(addr_first, 1'b1);
                            end
                        end
                        ST_ADDR: begin
                            if (id_reg != '0) begin
                                res.r0 = mk_xfer(addr_more, 1'b1);
                            end else if (op_reg == OPER_READ) begin
                                res.r0 = mk_xfer(PAUSE_BYTE, rem_reg != '0);
                            end else begin
                                res.r0 = mk_kind(KIND_WANT);
                            end
                        end
                        ST_RD_DATA: begin
                            res.count = 2'd2;
                            res.r0    = mk_data(data_byte);
                            res.r1    = mk_xfer(PAUSE_BYTE, rem_dec != '0);
                        end
                        ST_ID_DATA: begin
                            res.count = 2'd2;
                            res.r0    = mk_data(data_byte);
                            res.r1    = mk_xfer(PAUSE_BYTE, id_dec != '0);
                        end
                        ST_PAY_SENT: begin
                            res.r0 = (pg_dec != '0) ? mk_kind(KIND_WANT)
                                                    : mk_xfer(PAUSE_BYTE, 1'b0);
                        end
                        ST_PG_PAUSE:   res.r0 = mk_xfer(OP_WRDI, 1'b1);
                        ST_WRDI_CMD:   res.r0 = mk_xfer(PAUSE_BYTE, 1'b0);
                        ST_WRDI_PAUSE: begin
                            res.r0 = (rem_reg != '0) ? mk_xfer(OP_RDSR, 1'b1)
                                                     : mk_kind(KIND_DONE);
                        end
                        ST_END_PAUSE:  res.r0 = mk_kind(KIND_DONE);
                        default:       res.count = 2'd0;
                    endcase
                end
                MODE_PAYLOAD: begin
                    if (step_reg == ST_PAY_WAIT) begin
                        res.count = 2'd1;
                        res.r0    = mk_xfer(data_byte, 1'b1);
                    end
                end
                default: ;
            endcase
        end
        res.r0.last = (res.count == 2'd1);
        res.r1.last = (res.count == 2'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
            op_reg   <= OPER_READ;
            cur_reg  <= '0;
            rem_reg  <= '0;
            pg_reg   <= '0;
            stat_reg <= '0;
            id_reg   <= '0;
        end else begin
            step_reg <= step_next;
            op_reg   <= op_next;
            cur_reg  <= cur_next;
            rem_reg  <= rem_next;
            pg_reg   <= pg_next;
            stat_reg <= stat_next;
            id_reg   <= id_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sfcs_fifo.sv
`default_nettype none

module sfcs_fifo
    import sfcs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire res_pair_t push,
    output logic           room2,
    output logic           out_valid,
    input  wire logic      out_ready,
    output res_t           out_res
);

    res_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic                 pop;

    assign out_valid = cnt_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign room2     = cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        cnt_next    = cnt_reg + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + FIFO_AW'(1)] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/spi_flash_command_sequencer_unit.sv
// a taken beat is held in the input register, then its results go to the output queue
// throughput: one input beat per cycle while the output queue has room for two results;
//   output one beat per cycle under m_tready, so read or id data beats can hold the input side
// reset: synchronous active-low aresetn, sequencer idle, device_size back to 16 MiB,
//   input and output queues empty
`default_nettype none

module spi_flash_command_sequencer_unit
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [LEN_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // address[23:0], length[48:24], data_byte[56:49]
    input  wire logic [2:0]           s_tuser,   // mode[2:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // spi_byte[7:0], select_active[8], host_byte[16:9]
    output logic [2:0]                m_tuser,   // kind[2:0]
    output logic                      m_tlast
);

    logic [LEN_W-1:0]        dev_size_reg;
    logic                    in_valid_reg;
    logic [2:0]              mode_reg;
    logic [ADDR_FIELD_W-1:0] addr_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [BYTE_W-1:0]       data_reg;
    logic                    fifo_room2;
    logic                    proc_fire;
    res_pair_t               res;
    res_t                    out_res;

    assign proc_fire = in_valid_reg && fifo_room2;
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_size_reg <= DEVICE_SIZE_RESET;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                dev_size_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    // beat payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            mode_reg <= s_tuser;
            addr_reg <= s_tdata[23:0];
            len_reg  <= s_tdata[48:24];
            data_reg <= s_tdata[56:49];
        end
    end

    sfcs_core #(
        .PAGE_BYTES (PAGE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (proc_fire),
        .mode        (mode_reg),
        .address     (addr_reg),
        .length      (len_reg),
        .data_byte   (data_reg),
        .device_size (dev_size_reg),
        .res         (res)
    );

    sfcs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res),
        .room2     (fifo_room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = M_TDATA_W'({out_res.host_byte, out_res.select_active, out_res.spi_byte});
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire
